@@ rtl/core/tcep_pkg.sv @@
// Shared types and constants for the text color escape parser.
// No dependencies.
package tcep_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int FIELD_W = 10;
  localparam int COLOR_W = 24;
  localparam int NIB_W   = 4;
  localparam int FIELD_MAX = 1023;

  localparam logic [BYTE_W-1:0] CH_BELL    = 8'h07;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_UPPER_X = 8'h58;
  localparam logic [BYTE_W-1:0] CH_LOWER_X = 8'h78;

  localparam logic [BYTE_W-1:0] ESC_KIND_FG = 8'h01;
  localparam logic [BYTE_W-1:0] ESC_KIND_BG = 8'h02;

  localparam logic [KIND_W-1:0] RES_GLYPH     = 3'd0;
  localparam logic [KIND_W-1:0] RES_SET_FG    = 3'd1;
  localparam logic [KIND_W-1:0] RES_SET_BG    = 3'd2;
  localparam logic [KIND_W-1:0] RES_TRUNCATED = 3'd3;
  localparam logic [KIND_W-1:0] RES_BAD_KIND  = 3'd4;

  typedef enum logic [1:0] {
    CLS_GLYPH,
    CLS_NEWLINE,
    CLS_RETURN,
    CLS_BELL
  } char_class_t;

  typedef enum logic [3:0] {
    PH_TEXT  = 4'd0,
    PH_KIND  = 4'd1,
    PH_FIRST = 4'd2,
    PH_D2    = 4'd3,
    PH_D3    = 4'd4,
    PH_D4    = 4'd5,
    PH_D5    = 4'd6,
    PH_D6    = 4'd7
  } phase_t;

  // One classified byte as it travels from front to back.
  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic              last;
    char_class_t       cls;
    logic [NIB_W-1:0]  nibble;
    logic              is_x;
  } cls_item_t;

  function automatic logic [NIB_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
    logic [NIB_W-1:0] v;
    v = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = NIB_W'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = NIB_W'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = NIB_W'(c - 8'h61 + 8'd10);
    end
    return v;
  endfunction

endpackage

@@ rtl/core/tcep_front.sv @@
// Front end: classifies each incoming byte and decodes its hex nibble.
// Depends on tcep_pkg.
module tcep_front import tcep_pkg::*; (
  input  logic [BYTE_W-1:0] char_in,
  input  logic              is_last,
  output cls_item_t         item
);

  always_comb begin
    item.code   = char_in;
    item.last   = is_last;
    item.nibble = hex_value(char_in);
    item.is_x   = (char_in == CH_UPPER_X) || (char_in == CH_LOWER_X);
    priority if (char_in == CH_NEWLINE) begin
      item.cls = CLS_NEWLINE;
    end else if (char_in == CH_RETURN) begin
      item.cls = CLS_RETURN;
    end else if (char_in == CH_BELL) begin
      item.cls = CLS_BELL;
    end else begin
      item.cls = CLS_GLYPH;
    end
  end

endmodule

@@ rtl/core/tcep_queue.sv @@
// Two-entry queue of classified bytes between front and back end.
// Depends on tcep_pkg.
module tcep_queue import tcep_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output cls_item_t head
);

  cls_item_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/core/tcep_back.sv @@
// Back end: escape parse state, position counters and the result register.
// Depends on tcep_pkg.
module tcep_back import tcep_pkg::*; #(
  parameter int COUNTER_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  cls_item_t           item,
  output logic                item_take,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KIND_W-1:0]   out_result_kind,
  output logic [BYTE_W-1:0]   out_glyph_code,
  output logic [FIELD_W-1:0]  out_column,
  output logic [FIELD_W-1:0]  out_row,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic                out_opaque,
  output logic                out_end_of_string
);

  localparam int CB = COUNTER_BITS;
  localparam int EW = (CB > FIELD_W) ? CB : FIELD_W;
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
  localparam logic [EW-1:0] SAT_MAX = EW'(FIELD_MAX);

  phase_t              phase_r, phase_nxt;
  logic [BYTE_W-1:0]   kind_r, kind_nxt;
  logic [COLOR_W-1:0]  acc_r, acc_nxt;
  logic [CB-1:0]       col_r, col_nxt, row_r, row_nxt;
  logic                halted_r, halted_nxt;

  logic                emit;
  logic [KIND_W-1:0]   res_kind;
  logic [BYTE_W-1:0]   res_glyph;
  logic [FIELD_W-1:0]  res_col, res_row;
  logic [COLOR_W-1:0]  res_color;
  logic                res_opaque;

  logic                out_valid_r;
  logic [KIND_W-1:0]   kind_out_r;
  logic [BYTE_W-1:0]   glyph_out_r;
  logic [FIELD_W-1:0]  col_out_r, row_out_r;
  logic [COLOR_W-1:0]  color_out_r;
  logic                opaque_out_r, eos_out_r;

  logic [EW-1:0]       col_ext, row_ext;
  logic [FIELD_W-1:0]  col_sat, row_sat;

  assign item_take = item_valid && !(out_valid_r && out_stall);

  assign col_ext = EW'(col_r);
  assign row_ext = EW'(row_r);
  assign col_sat = (col_ext > SAT_MAX) ? FIELD_W'(SAT_MAX) : FIELD_W'(col_ext);
  assign row_sat = (row_ext > SAT_MAX) ? FIELD_W'(SAT_MAX) : FIELD_W'(row_ext);

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    acc_nxt    = acc_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    halted_nxt = halted_r;
    emit       = 1'b0;
    res_kind   = RES_GLYPH;
    res_glyph  = '0;
    res_col    = '0;
    res_row    = '0;
    res_color  = '0;
    res_opaque = 1'b0;

    if (!halted_r) begin
      unique case (phase_r)
        PH_TEXT: begin
          unique case (item.cls)
            CLS_NEWLINE: begin
              if (row_r != CNT_MAX) begin
                row_nxt = row_r + CB'(1);
              end
              col_nxt = '0;
            end
            CLS_RETURN: begin
              col_nxt = '0;
            end
            CLS_BELL: begin
              phase_nxt = PH_KIND;
              acc_nxt   = '0;
              kind_nxt  = '0;
            end
            CLS_GLYPH: begin
              emit      = 1'b1;
              res_kind  = RES_GLYPH;
              res_glyph = item.code;
              res_col   = col_sat;
              res_row   = row_sat;
              if (col_r != CNT_MAX) begin
                col_nxt = col_r + CB'(1);
              end
            end
            default: ;
          endcase
        end
        PH_KIND: begin
          kind_nxt  = item.code;
          phase_nxt = PH_FIRST;
        end
        PH_FIRST: begin
          if (item.is_x) begin
            acc_nxt   = '0;
            phase_nxt = PH_TEXT;
            emit      = 1'b1;
            if (kind_r == ESC_KIND_FG || kind_r == ESC_KIND_BG) begin
              res_kind = (kind_r == ESC_KIND_FG) ? RES_SET_FG : RES_SET_BG;
            end else begin
              res_kind   = RES_BAD_KIND;
              halted_nxt = 1'b1;
            end
          end else begin
            acc_nxt   = COLOR_W'(item.nibble);
            phase_nxt = PH_D2;
          end
        end
        PH_D2, PH_D3, PH_D4, PH_D5: begin
          acc_nxt   = {acc_r[COLOR_W-NIB_W-1:0], item.nibble};
          phase_nxt = phase_t'(phase_r + 4'd1);
        end
        PH_D6: begin
          acc_nxt   = {acc_r[COLOR_W-NIB_W-1:0], item.nibble};
          phase_nxt = PH_TEXT;
          emit      = 1'b1;
          if (kind_r == ESC_KIND_FG || kind_r == ESC_KIND_BG) begin
            res_kind   = (kind_r == ESC_KIND_FG) ? RES_SET_FG : RES_SET_BG;
            res_color  = {acc_r[COLOR_W-NIB_W-1:0], item.nibble};
            res_opaque = 1'b1;
          end else begin
            res_kind   = RES_BAD_KIND;
            halted_nxt = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_TEXT;
        end
      endcase

      // String ends with an escape still open
      if (item.last && phase_nxt != PH_TEXT) begin
        emit       = 1'b1;
        res_kind   = RES_TRUNCATED;
        res_glyph  = '0;
        res_col    = '0;
        res_row    = '0;
        res_color  = '0;
        res_opaque = 1'b0;
      end
    end

    if (item.last) begin
      phase_nxt  = PH_TEXT;
      kind_nxt   = '0;
      acc_nxt    = '0;
      col_nxt    = '0;
      row_nxt    = '0;
      halted_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TEXT;
      kind_r      <= '0;
      acc_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_take) begin
        phase_r  <= phase_nxt;
        kind_r   <= kind_nxt;
        acc_r    <= acc_nxt;
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        halted_r <= halted_nxt;
      end
      if (item_take && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      kind_out_r   <= res_kind;
      glyph_out_r  <= res_glyph;
      col_out_r    <= res_col;
      row_out_r    <= res_row;
      color_out_r  <= res_color;
      opaque_out_r <= res_opaque;
      eos_out_r    <= item.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = kind_out_r;
  assign out_glyph_code    = glyph_out_r;
  assign out_column        = col_out_r;
  assign out_row           = row_out_r;
  assign out_red           = color_out_r[23:16];
  assign out_green         = color_out_r[15:8];
  assign out_blue          = color_out_r[7:0];
  assign out_opaque        = opaque_out_r;
  assign out_end_of_string = eos_out_r;

endmodule

@@ rtl/core/text_color_escape_parser_unit.sv @@
// Overlay text escape parser: top level joining front end, queue and back end.
// Depends on tcep_pkg, tcep_front, tcep_queue, tcep_back.
//
// Usage: text bytes enter on in_char_in with in_is_last on the final byte of a
// string; a transaction happens when in_valid is high and in_stall is low.
// Each byte yields zero or one result on the out_ channel (glyph, color set,
// truncated escape or bad escape kind); a result transaction happens when
// out_valid is high and out_stall is low.
// Throughput: one byte per cycle sustained while out_stall is low. A byte is
// classified and written into the two-entry queue when accepted, then parsed
// from the queue head; its result is registered in the result register that
// drives out_valid.
// in_stall rises only when the two-entry queue is full, which happens when
// the single result register is held by out_stall and the parser backs up.
// Reset (rst_n low, synchronous) empties the queue, drops any pending result
// and returns the parser to text mode with both counters at zero.
module text_color_escape_parser_unit import tcep_pkg::*; #(
  parameter int COUNTER_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_char_in,
  input  logic               in_is_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  out_result_kind,
  output logic [BYTE_W-1:0]  out_glyph_code,
  output logic [FIELD_W-1:0] out_column,
  output logic [FIELD_W-1:0] out_row,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               out_opaque,
  output logic               out_end_of_string
);

  cls_item_t front_item, head_item;
  logic      q_full, q_not_empty, q_pop;

  tcep_front u_front (
    .char_in (in_char_in),
    .is_last (in_is_last),
    .item    (front_item)
  );

  tcep_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  assign in_stall = q_full;

  tcep_back #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (q_not_empty),
    .item              (head_item),
    .item_take         (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_glyph_code    (out_glyph_code),
    .out_column        (out_column),
    .out_row           (out_row),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_opaque        (out_opaque),
    .out_end_of_string (out_end_of_string)
  );

endmodule
